// ----- rtl/lcd4_pkg.sv -----
// ----------------------------------------------------------------------------
// lcd4_pkg
// Types, codes and fixed tables shared by the 4-bit character LCD controller.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  // request codes
  localparam logic [2:0] REQ_CMD  = 3'd0;
  localparam logic [2:0] REQ_DATA = 3'd1;
  localparam logic [2:0] REQ_GOTO = 3'd2;
  localparam logic [2:0] REQ_NUM  = 3'd3;
  localparam logic [2:0] REQ_INIT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_PULSE   = 2'd0;
  localparam logic [1:0] CFG_CMD_DLY = 2'd1;
  localparam logic [1:0] CFG_CLR_DLY = 2'd2;
  localparam logic [1:0] CFG_PWR_DLY = 2'd3;

  localparam logic [15:0] PULSE_RST   = 16'd1;
  localparam logic [15:0] CMD_DLY_RST = 16'd1000;
  localparam logic [15:0] CLR_DLY_RST = 16'd5000;
  localparam logic [15:0] PWR_DLY_RST = 16'd3000;

  // back-end operation codes
  localparam logic [2:0] OP_BYTE    = 3'd0;  // six pin states
  localparam logic [2:0] OP_NIBBLE  = 3'd1;  // three pin states
  localparam logic [2:0] OP_DLY_CMD = 3'd2;  // one state, previous levels
  localparam logic [2:0] OP_DLY_CLR = 3'd3;
  localparam logic [2:0] OP_DLY_PWR = 3'd4;  // one state, all low

  localparam logic [7:0] LINE1_BASE      = 8'h80;
  localparam logic [7:0] LINE2_BASE      = 8'hC0;
  localparam logic [7:0] SET_FUNCTION    = 8'h28;
  localparam logic [7:0] SET_ENTRY       = 8'h06;
  localparam logic [7:0] CLEAR_DISPLAY   = 8'h01;
  localparam logic [7:0] DISPLAY_ON      = 8'h0C;
  localparam logic [7:0] FOUR_BIT_NIBBLE = 8'h02;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;

  localparam int QDEPTH = 4;
  localparam logic [2:0] LAST_PLACE = 3'd4;   // ones place of five digits
  localparam logic [3:0] INIT_LAST  = 4'd10;  // eleven init operations

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] value;
    logic [4:0]  col;
    logic [1:0]  line;
  } req_t;

  typedef struct packed {
    logic        rs_pin;
    logic        enable_pin;
    logic [3:0]  data_nibble;
    logic [15:0] hold_ticks;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       rs;
    logic [7:0] data;
    logic       last;
  } op_t;

  typedef struct packed {
    logic [15:0] pulse;
    logic [15:0] cmd_dly;
    logic [15:0] clr_dly;
    logic [15:0] pwr_dly;
  } cfg_t;

  function automatic logic [15:0] pow10(input logic [2:0] place);
    case (place)
      3'd0:    pow10 = 16'd10000;
      3'd1:    pow10 = 16'd1000;
      3'd2:    pow10 = 16'd100;
      3'd3:    pow10 = 16'd10;
      default: pow10 = 16'd1;
    endcase
  endfunction

  function automatic op_t init_op(input logic [3:0] step);
    op_t o;
    o.rs   = 1'b0;
    o.last = 1'b0;
    o.data = 8'h00;
    o.kind = OP_DLY_CMD;
    case (step)
      4'd0:    o.kind = OP_DLY_PWR;
      4'd1:    begin o.kind = OP_NIBBLE; o.data = FOUR_BIT_NIBBLE; end
      4'd3:    begin o.kind = OP_BYTE;   o.data = SET_FUNCTION;    end
      4'd5:    begin o.kind = OP_BYTE;   o.data = SET_ENTRY;       end
      4'd7:    begin o.kind = OP_BYTE;   o.data = CLEAR_DISPLAY;   end
      4'd8:    o.kind = OP_DLY_CLR;
      4'd9:    begin o.kind = OP_BYTE;   o.data = DISPLAY_ON;      end
      4'd10:   o.last = 1'b1;
      default: o.kind = OP_DLY_CMD;
    endcase
    return o;
  endfunction

endpackage

// ----- rtl/lcd4_fifo.sv -----
// ----------------------------------------------------------------------------
// lcd4_fifo
// Small operation queue between the request front end and the pin sequencer.
// ----------------------------------------------------------------------------
module lcd4_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcd4_pkg::op_t  push_op,
  input  logic           pop,
  output lcd4_pkg::op_t  head,
  output logic           full,
  output logic           empty
);
  import lcd4_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  op_t             mem [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            wr;
  logic            rd;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= push_op;
  end

endmodule

// ----- rtl/lcd4_front.sv -----
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts requests and turns each into byte, nibble and delay operations.
// ----------------------------------------------------------------------------
module lcd4_front #(
  parameter int COLUMNS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lcd4_pkg::req_t req,
  output logic           push,
  output lcd4_pkg::op_t  push_op,
  input  logic           full
);
  import lcd4_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ONE  = 2'd1;
  localparam logic [1:0] F_NUM  = 2'd2;
  localparam logic [1:0] F_INIT = 2'd3;

  localparam logic [5:0] COL_MAX = 6'(COLUMNS);

  logic [1:0]  state;
  op_t         one_op;
  logic [15:0] rem;
  logic [2:0]  place;
  logic [3:0]  dig;
  logic        started;
  logic [3:0]  istep;

  logic        accept;
  logic        goto_ok;
  logic [7:0]  goto_base;
  logic [15:0] pw;
  logic        digit_out;

  assign req_stall = (state != F_IDLE);
  assign accept    = req_valid && !req_stall;
  assign pw        = pow10(place);
  assign digit_out = (dig != 4'd0) || started || (place == LAST_PLACE);

  always_comb begin
    goto_base = (req.line == 2'd2) ? LINE2_BASE : LINE1_BASE;
    goto_ok   = ((req.line == 2'd1) || (req.line == 2'd2)) &&
                ({1'b0, req.col} >= 6'd1) && ({1'b0, req.col} <= COL_MAX);
  end

  always_comb begin
    push    = 1'b0;
    push_op = one_op;
    case (state)
      F_ONE: push = 1'b1;
      F_NUM: begin
        push         = (rem < pw) && digit_out;
        push_op.kind = OP_BYTE;
        push_op.rs   = 1'b1;
        push_op.data = ASCII_ZERO + {4'd0, dig};
        push_op.last = (place == LAST_PLACE);
      end
      F_INIT: begin
        push    = 1'b1;
        push_op = init_op(istep);
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            case (req.req_type)
              REQ_CMD, REQ_DATA: begin
                one_op.kind <= OP_BYTE;
                one_op.rs   <= (req.req_type == REQ_DATA);
                one_op.data <= req.value[7:0];
                one_op.last <= 1'b1;
                state       <= F_ONE;
              end
              REQ_GOTO: begin
                one_op.kind <= OP_BYTE;
                one_op.rs   <= 1'b0;
                one_op.data <= goto_base | {3'd0, req.col - 5'd1};
                one_op.last <= 1'b1;
                if (goto_ok) state <= F_ONE;
              end
              REQ_NUM: begin
                rem     <= req.value;
                place   <= 3'd0;
                dig     <= 4'd0;
                started <= 1'b0;
                state   <= F_NUM;
              end
              REQ_INIT: begin
                istep <= 4'd0;
                state <= F_INIT;
              end
              default: state <= F_IDLE;  // unknown type: nothing sent
            endcase
          end
        end
        F_ONE: begin
          if (!full) state <= F_IDLE;
        end
        F_NUM: begin
          // repeated subtraction, one step a cycle
          if (rem >= pw) begin
            rem <= rem - pw;
            dig <= dig + 4'd1;
          end else if (!digit_out || !full) begin
            started <= started || digit_out;
            dig     <= 4'd0;
            place   <= place + 3'd1;
            if (place == LAST_PLACE) state <= F_IDLE;
          end
        end
        F_INIT: begin
          if (!full) begin
            istep <= istep + 4'd1;
            if (istep == INIT_LAST) state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/lcd4_back.sv -----
// ----------------------------------------------------------------------------
// lcd4_back
// Pin sequencer: expands queued operations into timed pin states.
// ----------------------------------------------------------------------------
module lcd4_back (
  input  logic           clk,
  input  logic           rst,
  input  lcd4_pkg::cfg_t cfg,
  input  lcd4_pkg::op_t  head,
  input  logic           empty,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output lcd4_pkg::res_t res
);
  import lcd4_pkg::*;

  logic        busy;
  op_t         op;
  logic [2:0]  step;
  logic        cur_rs;
  logic [3:0]  cur_nib;

  logic        load;
  logic [2:0]  step_last;
  res_t        pin;

  assign pop  = !busy && !empty;
  assign load = busy && (!res_valid || !res_stall);

  always_comb begin
    pin.rs_pin      = op.rs;
    pin.enable_pin  = 1'b0;
    pin.data_nibble = op.data[3:0];
    pin.hold_ticks  = cfg.pulse;
    step_last       = 3'd0;
    case (op.kind)
      OP_BYTE: begin
        step_last       = 3'd5;
        pin.data_nibble = (step < 3'd3) ? op.data[7:4] : op.data[3:0];
        pin.enable_pin  = (step == 3'd1) || (step == 3'd4);
      end
      OP_NIBBLE: begin
        step_last      = 3'd2;
        pin.enable_pin = (step == 3'd1);
      end
      OP_DLY_CMD: begin
        pin.rs_pin      = cur_rs;
        pin.data_nibble = cur_nib;
        pin.hold_ticks  = cfg.cmd_dly;
      end
      OP_DLY_CLR: begin
        pin.rs_pin      = cur_rs;
        pin.data_nibble = cur_nib;
        pin.hold_ticks  = cfg.clr_dly;
      end
      default: begin  // power-up wait
        pin.rs_pin      = 1'b0;
        pin.data_nibble = 4'd0;
        pin.hold_ticks  = cfg.pwr_dly;
      end
    endcase
    pin.last = op.last && (step == step_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= 3'd0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (load) begin
        step <= step + 3'd1;
        if (step == step_last) busy <= 1'b0;
      end
      if (load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) op <= head;
    if (load) begin
      res     <= pin;
      cur_rs  <= pin.rs_pin;
      cur_nib <= pin.data_nibble;
    end
  end

endmodule

// ----- rtl/char_lcd_4bit_interface_controller.sv -----
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_controller
// 4-bit character LCD driver: requests in, timed pin states out.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req): command byte, data byte,
// goto, decimal number or init. A request is taken when req_valid is high
// and req_stall is low. The front end stalls while it is still splitting the
// previous request into operations, and longer while the queue is full; a
// number is split by a digit loop that does one subtraction of a power of
// ten per cycle and then moves on to the next digit place.
// Result channel (res_valid / res_stall / res): one pin state per item with
// its hold time; last marks the final state of a request. The pin sequencer
// gives one state per cycle while res_stall is low and fetches each queued
// operation in an idle step of its own. The first result of a byte, goto or
// init request passes the front-end state register, the queue, the operation
// register and the result register; a number's first digit also waits on
// the digit loop. While res_stall is high the result register holds and the
// queue fills; the front end works on until the four-entry queue is full.
// Config port (cfg_we / cfg_index / cfg_data): write only, while idle.
// Reset (rst, synchronous): queue and sequencer empty, registers to defaults.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_controller #(
  parameter int COLUMNS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lcd4_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output lcd4_pkg::res_t res,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import lcd4_pkg::*;

  cfg_t cfg;
  logic push;
  op_t  push_op;
  logic full;
  logic empty;
  logic pop;
  op_t  head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse   <= PULSE_RST;
      cfg.cmd_dly <= CMD_DLY_RST;
      cfg.clr_dly <= CLR_DLY_RST;
      cfg.pwr_dly <= PWR_DLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PULSE:   cfg.pulse   <= cfg_data;
        CFG_CMD_DLY: cfg.cmd_dly <= cfg_data;
        CFG_CLR_DLY: cfg.clr_dly <= cfg_data;
        default:     cfg.pwr_dly <= cfg_data;
      endcase
    end
  end

  lcd4_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_op   (push_op),
    .full      (full)
  );

  lcd4_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  lcd4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a strobe-high state never ends a request
  a_enable_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.enable_pin |-> !res.last)
    else $error("enable high on last state");

  // strobe-high states carry the pulse time
  a_enable_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.enable_pin |-> res.hold_ticks == cfg.pulse)
    else $error("enable state hold differs from pulse time");

  // unknown request types are dropped without stalling
  a_unknown_drop: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.req_type > REQ_INIT) |=> !req_stall)
    else $error("unknown request type stalled the front end");

endmodule
